@@ src/cfcd_pkg.sv @@
// shared types and constants of the cobs crc-8 frame decoder
package cfcd_pkg;

  localparam int unsigned MAX_FRAME_DEF = 256;

  localparam logic [7:0] CRC_INIT = 8'h55;
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] RUN_STEP = 8'd64;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_RUN,
    ST_STAT
  } state_t;

endpackage

@@ src/cfcd_ifs.sv @@
// item channels of the cobs crc-8 frame decoder
interface cfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface cfcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] frame_length;
  logic       last_of_run;

  modport source (output valid, output kind, output data_byte, output frame_length,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_length,
                input last_of_run, output ready);
endinterface

@@ src/cfcd_crc8_unit.sv @@
// one byte step of the reflected crc-8, polynomial 0x31
module cfcd_crc8_unit (
  input  logic [7:0] crc_i,
  input  logic [7:0] data_i,
  output logic [7:0] crc_o
);

  always_comb begin
    logic [7:0] c;
    c = crc_i ^ data_i;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ cfcd_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

@@ src/cobs_crc8_frame_decoder.sv @@
// Decodes a COBS byte stream whose code bytes carry up to 63 literal bytes in the low six bits
// and a run of zero bytes in steps of 64 in the upper bits; a zero byte ends the frame. Each
// decoded byte is held back by one byte, so the final byte of a frame (its CRC-8, reflected
// 0x31, init 0x55) is checked rather than passed out. A frame end gives one good or bad status
// item with the payload length. Bytes beyond MAX_FRAME stored bytes are dropped. An input item
// is accepted in the idle state; then each stored byte (its literal and up to three zero-run
// bytes) or the frame status is handled in a step of its own, paced by the single CRC step
// unit and the one result register; a result not taken stalls these steps. Input is taken only
// while the sequencer is idle.
module cobs_crc8_frame_decoder #(
  parameter int unsigned MAX_FRAME = cfcd_pkg::MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cfcd_in_if.sink           in_chan,
  cfcd_out_if.source        out_chan
);

  localparam int unsigned SC_W = $clog2(MAX_FRAME + 1);
  localparam logic [SC_W-1:0] MAX_SC = SC_W'(MAX_FRAME);

  cfcd_pkg::state_t state_r, state_nxt;
  logic [7:0]      cc_r, cc_nxt;
  logic [SC_W-1:0] sc_r, sc_nxt;
  logic [7:0]      held_r, held_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic [7:0]      lit_r, lit_nxt;

  logic            out_valid_r, out_valid_nxt;
  cfcd_pkg::kind_t out_kind_r, out_kind_nxt;
  logic [7:0]      out_data_r, out_data_nxt;
  logic [7:0]      out_len_r, out_len_nxt;
  logic            out_last_r, out_last_nxt;

  logic [7:0]      crc_step;
  logic            slot_free;
  logic            in_acc;
  logic            sc_sat;
  logic            sc_emit;
  logic [SC_W:0]   sc_inc;
  logic            next_sat;
  logic            store_req;
  logic            store_go;
  logic [7:0]      store_val;
  logic            store_last;
  logic            run_follow;
  logic [7:0]      cc_after;
  logic [SC_W-1:0] len_full;
  logic [SC_W+7:0] len_ext;

  cfcd_crc8_unit u_crc (
    .crc_i  (crc_r),
    .data_i (held_r),
    .crc_o  (crc_step)
  );

  assign in_chan.ready         = (state_r == cfcd_pkg::ST_IDLE);
  assign in_acc                = in_chan.valid && in_chan.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.kind         = out_kind_r;
  assign out_chan.data_byte    = out_data_r;
  assign out_chan.frame_length = out_len_r;
  assign out_chan.last_of_run  = out_last_r;

  assign slot_free  = !out_valid_r || out_chan.ready;
  assign sc_sat     = (sc_r >= MAX_SC);
  assign sc_emit    = (sc_r != '0) && !sc_sat;
  assign sc_inc     = {1'b0, sc_r} + 1'b1;
  assign next_sat   = (sc_inc >= {1'b0, MAX_SC});
  assign run_follow = (cc_r[5:0] == 6'd0) && (cc_r != 8'd0);
  assign cc_after   = cc_r - cfcd_pkg::RUN_STEP;
  assign len_full   = (sc_r != '0) ? sc_r - 1'b1 : '0;
  assign len_ext    = {8'd0, len_full};

  always_comb begin
    state_nxt     = state_r;
    cc_nxt        = cc_r;
    sc_nxt        = sc_r;
    held_nxt      = held_r;
    crc_nxt       = crc_r;
    lit_nxt       = lit_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    store_req     = 1'b0;
    store_val     = 8'd0;
    store_last    = 1'b0;

    unique case (state_r)
      cfcd_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.in_byte == 8'd0) begin
            state_nxt = cfcd_pkg::ST_STAT;
          end else if (cc_r == 8'd0) begin
            cc_nxt    = in_chan.in_byte;
            state_nxt = (in_chan.in_byte[5:0] == 6'd0) ? cfcd_pkg::ST_RUN : cfcd_pkg::ST_IDLE;
          end else begin
            cc_nxt    = cc_r - 8'd1;
            lit_nxt   = in_chan.in_byte;
            state_nxt = cfcd_pkg::ST_LIT;
          end
        end
      end
      cfcd_pkg::ST_LIT: begin
        store_req  = 1'b1;
        store_val  = lit_r;
        store_last = !run_follow || next_sat;
      end
      cfcd_pkg::ST_RUN: begin
        store_req  = 1'b1;
        store_val  = 8'd0;
        store_last = (cc_after == 8'd0) || next_sat;
      end
      cfcd_pkg::ST_STAT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = (cc_r != 8'd0 || sc_r <= SC_W'(1) || held_r != crc_r) ?
                          cfcd_pkg::KIND_BAD : cfcd_pkg::KIND_GOOD;
          out_data_nxt  = 8'd0;
          out_len_nxt   = len_ext[7:0];
          out_last_nxt  = 1'b1;
          cc_nxt        = 8'd0;
          sc_nxt        = '0;
          held_nxt      = 8'd0;
          crc_nxt       = cfcd_pkg::CRC_INIT;
          state_nxt     = cfcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cfcd_pkg::ST_IDLE;
      end
    endcase

    store_go = store_req && (!sc_emit || slot_free);

    if (store_go) begin
      if (!sc_sat) begin
        held_nxt = store_val;
        sc_nxt   = sc_inc[SC_W-1:0];
        if (sc_emit) begin
          crc_nxt       = crc_step;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = cfcd_pkg::KIND_DATA;
          out_data_nxt  = held_r;
          out_len_nxt   = 8'd0;
          out_last_nxt  = store_last;
        end
      end
      if (state_r == cfcd_pkg::ST_LIT) begin
        state_nxt = run_follow ? cfcd_pkg::ST_RUN : cfcd_pkg::ST_IDLE;
      end else begin
        cc_nxt    = cc_after;
        state_nxt = (cc_after == 8'd0) ? cfcd_pkg::ST_IDLE : cfcd_pkg::ST_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfcd_pkg::ST_IDLE;
      cc_r        <= 8'd0;
      sc_r        <= '0;
      held_r      <= 8'd0;
      crc_r       <= cfcd_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cc_r        <= cc_nxt;
      sc_r        <= sc_nxt;
      held_r      <= held_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r      <= lit_nxt;
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != cfcd_pkg::KIND_DATA |-> out_last_r)
    else $error("status item without last_of_run");

  a_data_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == cfcd_pkg::KIND_DATA |-> out_len_r == 8'd0)
    else $error("data item carries a frame length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= MAX_SC)
    else $error("stored count beyond frame limit");

  a_zero_to_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_chan.in_byte == 8'd0 |=> state_r == cfcd_pkg::ST_STAT)
    else $error("frame end did not start a status");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the cobs crc-8 frame decoder: directed and random byte streams against a predictor
`timescale 1ns / 1ps

module tb_top;
  import cfcd_pkg::*;

  localparam int unsigned FRAME_LIMIT = MAX_FRAME_DEF;
  localparam int unsigned RANDOM_ITEMS = 136;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned HOLD_AFTER = 60;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LOOK_CODE = 63;
  localparam int unsigned OVERRUN_ZEROS = 6;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       typed;
    kind_t      kind;
    logic [7:0] len;
  } stim_row_t;

  // typed status rows carry their expected status, the rest go through the predictor
  localparam stim_row_t DIRECTED [19] = '{
    '{8'h00, 1'b1, KIND_BAD,  8'd0},
    '{8'h01, 1'b0, KIND_DATA, 8'd0},
    '{8'hAB, 1'b0, KIND_DATA, 8'd0},
    '{8'h00, 1'b1, KIND_BAD,  8'd0},
    '{8'h40, 1'b0, KIND_DATA, 8'd0},
    '{8'h01, 1'b0, KIND_DATA, 8'd0},
    '{8'hE4, 1'b0, KIND_DATA, 8'd0},
    '{8'h00, 1'b1, KIND_GOOD, 8'd1},
    '{8'h03, 1'b0, KIND_DATA, 8'd0},
    '{8'h11, 1'b0, KIND_DATA, 8'd0},
    '{8'h00, 1'b1, KIND_BAD,  8'd0},
    '{8'hC3, 1'b0, KIND_DATA, 8'd0},
    '{8'hFF, 1'b0, KIND_DATA, 8'd0},
    '{8'h80, 1'b0, KIND_DATA, 8'd0},
    '{8'h7F, 1'b0, KIND_DATA, 8'd0},
    '{8'h00, 1'b0, KIND_DATA, 8'd0},
    '{8'h80, 1'b0, KIND_DATA, 8'd0},
    '{8'hC0, 1'b0, KIND_DATA, 8'd0},
    '{8'h00, 1'b0, KIND_DATA, 8'd0}
  };

  logic clk;
  logic rst_n = 1'b0;

  cfcd_in_if  in_chan ();
  cfcd_out_if out_chan ();

  cobs_crc8_frame_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic [7:0] dec_code;
  int         dec_stored;
  logic [7:0] dec_held;
  logic [7:0] dec_crc;
  result_t    step_buf [4];
  int         step_n;

  result_t    expected_results [$];
  result_t    want_res;
  logic [7:0] payload_q [$];
  logic [7:0] wire_q [$];

  logic       drv_typed;
  kind_t      drv_kind;
  logic [7:0] drv_len;

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned bytes_accepted;
  int unsigned results_checked;
  int unsigned good_seen;
  int unsigned bad_seen;
  int unsigned dropped_bytes;
  int unsigned four_result_steps;
  int unsigned burst_left;
  int unsigned cycle_count;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic clear_decoder();
    dec_code = 8'h00;
    dec_stored = 0;
    dec_held = 8'h00;
    dec_crc = CRC_INIT;
  endtask

  // store one decoded byte and release the one held before it
  task automatic store_decoded_byte(input logic [7:0] v);
    if (dec_stored >= FRAME_LIMIT) begin
      dropped_bytes++;
      return;
    end
    if (dec_stored >= 1) begin
      if (step_n < 4) begin
        step_buf[step_n] = '{KIND_DATA, dec_held, 8'h00, 1'b0};
        step_n++;
      end
      dec_crc = crc8_update(dec_crc, dec_held);
    end
    dec_held = v;
    dec_stored++;
  endtask

  task automatic decode_in_byte(input logic [7:0] b);
    int len;
    kind_t st;
    step_n = 0;
    if (b == 8'h00) begin
      len = (dec_stored >= 1) ? dec_stored - 1 : 0;
      st = (dec_code != 8'h00 || dec_stored <= 1 || dec_held != dec_crc) ? KIND_BAD : KIND_GOOD;
      step_buf[0] = '{st, 8'h00, 8'(len), 1'b0};
      step_n = 1;
      clear_decoder();
    end else begin
      if (dec_code == 8'h00) begin
        dec_code = b;
      end else begin
        dec_code = dec_code - 8'd1;
        store_decoded_byte(b);
      end
      if ((dec_code & 8'(LOOK_CODE)) == 8'h00) begin
        while (dec_code != 8'h00) begin
          store_decoded_byte(8'h00);
          dec_code = dec_code - RUN_STEP;
        end
      end
    end
    if (step_n == 4) four_result_steps++;
    for (int i = 0; i < step_n; i++) begin
      step_buf[i].last_of_run = (i == step_n - 1);
      expected_results.insert(expected_results.size(), step_buf[i]);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
             what, results_checked, got, want);
    mismatches++;
  endtask

  // input acceptance feeds the predictor, output acceptance is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        bytes_accepted++;
        decode_in_byte(in_chan.in_byte);
        if (drv_typed) begin
          expected_results[expected_results.size() - 1] = '{drv_kind, 8'h00, drv_len, 1'b1};
        end
      end
      if (out_chan.valid && out_chan.ready) begin
        if (out_chan.kind == KIND_GOOD) good_seen++;
        if (out_chan.kind == KIND_BAD) bad_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected item", out_chan.kind, 0);
        end else begin
          want_res = expected_results.pop_front();
          if (out_chan.kind !== want_res.kind)
            report_mismatch("kind", out_chan.kind, want_res.kind);
          if (out_chan.data_byte !== want_res.data_byte)
            report_mismatch("data_byte", out_chan.data_byte, want_res.data_byte);
          if (out_chan.frame_length !== want_res.frame_length)
            report_mismatch("frame_length", out_chan.frame_length, want_res.frame_length);
          if (out_chan.last_of_run !== want_res.last_of_run)
            report_mismatch("last_of_run", out_chan.last_of_run, want_res.last_of_run);
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: segments of steady, random and sparse ready, plus one long hold-off
  initial begin
    int unsigned seg_mode;
    int unsigned seg_len;
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      seg_mode = $urandom_range(0, 2);
      seg_len = $urandom_range(10, 60);
      repeat (seg_len) begin
        @(posedge clk);
        if (hold_left > 0) begin
          hold_left--;
          out_chan.ready <= 1'b0;
        end else if (!hold_done && bytes_accepted >= HOLD_AFTER) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES - 1;
          out_chan.ready <= 1'b0;
        end else if (seg_mode == 0) begin
          out_chan.ready <= 1'b1;
        end else if (seg_mode == 1) begin
          out_chan.ready <= 1'($urandom_range(0, 1));
        end else begin
          out_chan.ready <= ($urandom_range(0, 3) == 0);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input kind_t kind,
                           input logic [7:0] len);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.in_byte <= b;
    drv_typed <= typed;
    drv_kind <= kind;
    drv_len <= len;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic make_payload(input int n, input int zero_pct);
    payload_q.delete();
    repeat (n) begin
      payload_q.insert(payload_q.size(), ($urandom_range(0, 99) < zero_pct) ? 8'h00 :
                       8'($urandom_range(1, 255)));
    end
  endtask

  task automatic append_crc();
    logic [7:0] c;
    c = CRC_INIT;
    foreach (payload_q[i]) c = crc8_update(c, payload_q[i]);
    payload_q.insert(payload_q.size(), c);
  endtask

  // literal count in the low six bits, trailing zero run in the top two
  task automatic encode_frame();
    int i;
    int k;
    int lits;
    int zeros;
    int start;
    wire_q.delete();
    i = 0;
    while (i < payload_q.size()) begin
      start = i;
      lits = 0;
      while (i < payload_q.size() && payload_q[i] != 8'h00 && lits < LOOK_CODE) begin
        lits++;
        i++;
      end
      zeros = 0;
      while (i < payload_q.size() && payload_q[i] == 8'h00 && zeros < 3) begin
        zeros++;
        i++;
      end
      wire_q.insert(wire_q.size(), 8'(lits + zeros * 64));
      for (k = start; k < start + lits; k++) wire_q.insert(wire_q.size(), payload_q[k]);
    end
  endtask

  task automatic send_wire();
    foreach (wire_q[i]) send_byte(wire_q[i], 1'b0, KIND_DATA, 8'h00);
    send_byte(8'h00, 1'b0, KIND_DATA, 8'h00);
  endtask

  task automatic good_frame();
    make_payload(($urandom_range(0, 7) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24),
                 $urandom_range(0, 60));
    append_crc();
    encode_frame();
  endtask

  initial begin
    int unsigned pick;
    int unsigned random_start;
    int unsigned cut;
    mismatches = 0;
    items_sent = 0;
    bytes_accepted = 0;
    results_checked = 0;
    good_seen = 0;
    bad_seen = 0;
    dropped_bytes = 0;
    four_result_steps = 0;
    burst_left = 0;
    cycle_count = 0;
    clear_decoder();
    in_chan.valid <= 1'b0;
    in_chan.in_byte <= 8'h00;
    drv_typed <= 1'b0;
    drv_kind <= KIND_DATA;
    drv_len <= 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i].in_byte, DIRECTED[i].typed, DIRECTED[i].kind, DIRECTED[i].len);
    end
    drain_results();

    random_start = items_sent;
    // largest good frame, all zero payload, running on past the frame limit
    make_payload(FRAME_LIMIT - 1, 100);
    append_crc();
    repeat (OVERRUN_ZEROS) payload_q.insert(payload_q.size(), 8'h00);
    encode_frame();
    send_wire();

    while (items_sent - random_start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        good_frame();
      end else if (pick == 6) begin
        good_frame();
        wire_q[$urandom_range(0, wire_q.size() - 1)] = 8'($urandom_range(1, 255));
      end else if (pick == 7) begin
        good_frame();
        cut = $urandom_range(1, wire_q.size() - 1);
        while (wire_q.size() > cut) void'(wire_q.pop_back());
      end else if (pick == 8) begin
        wire_q.delete();
        repeat ($urandom_range(1, 12)) wire_q.insert(wire_q.size(), 8'($urandom_range(1, 255)));
      end else begin
        make_payload($urandom_range(0, 2), 30);
        encode_frame();
      end
      send_wire();
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("covered %0d input bytes, %0d results checked, %0d good and %0d bad frames",
             bytes_accepted, results_checked, good_seen, bad_seen);
    $display("bytes dropped past the frame limit %0d, bytes giving four results %0d",
             dropped_bytes, four_result_steps);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ cobs_crc8_frame_decoder.f @@
src/cfcd_pkg.sv
src/cfcd_ifs.sv
src/cfcd_crc8_unit.sv
src/cobs_crc8_frame_decoder.sv
tb/sv/tb_top.sv
